/* hw/rtl/tpr_pkg.sv */
`default_nettype none
package tpr_pkg;

	// trie pool and alphabet
	localparam int NODES    = 1024;
	localparam int ALPHABET = 26;

	localparam int NODE_W = $clog2(NODES);
	localparam int FREE_W = $clog2(NODES + 1);
	localparam int LET_W  = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
	// one row per node: ALPHABET child links plus the word end mark on top
	localparam int ROW_W  = ALPHABET * NODE_W + 1;
	localparam int LANES  = ALPHABET + 1;

	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADCH = 2'd2;

	// classified item as it travels from front to back
	typedef struct packed {
		logic             func;
		logic [7:0]       ch;
		logic             last;
		logic             is_letter;
		logic             is_space;
		logic [LET_W-1:0] letter;
	} item_t;

endpackage
`default_nettype wire

/* hw/rtl/tpr_front.sv */
`default_nettype none
module tpr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          func,
	input  wire logic [7:0]    ch,
	input  wire logic          word_end,
	output logic               push,
	output tpr_pkg::item_t     push_item,
	input  wire logic          push_ready
);
	import tpr_pkg::*;

	logic       v_s1;
	item_t      item_s1;
	item_t      cls;
	logic [7:0] d;

	// letter index and character class
	always_comb begin
		d             = ch - CH_A;
		cls.func      = func;
		cls.ch        = ch;
		cls.last      = word_end;
		cls.is_letter = (ch >= CH_A) && (d < 8'(ALPHABET));
		cls.is_space  = (ch == CH_SPACE);
		cls.letter    = d[LET_W-1:0];
	end

	assign in_ready  = !v_s1 || push_ready;
	assign push      = v_s1;
	assign push_item = item_s1;

	// one stage register ahead of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tpr_queue.sv */
`default_nettype none
module tpr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  tpr_pkg::item_t     push_item,
	output logic               push_ready,
	output logic               head_valid,
	output tpr_pkg::item_t     head,
	input  wire logic          pop
);
	import tpr_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// two-entry ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tpr_back.sv */
`default_nettype none
module tpr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  tpr_pkg::item_t     head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               emit,
	output logic [7:0]         out_char,
	output logic [1:0]         status
);
	import tpr_pkg::*;

	typedef enum logic [1:0] {S_INIT, S_IDLE, S_LOOK, S_CLEAR} state_t;
	typedef enum logic [1:0] {M_MATCH, M_ECHO, M_SUPP} mode_t;

	state_t              state_q;
	mode_t               tmode_q;
	item_t               item_q;
	logic [NODE_W-1:0]   tcur_q;
	logic [NODE_W-1:0]   icur_q;
	logic [FREE_W-1:0]   nfree_q;
	logic                drop_q;
	logic                out_valid_q;
	logic                emit_q;
	logic [7:0]          out_char_q;
	logic [1:0]          status_q;

	// child table rows, mark in the top bit
	logic [ROW_W-1:0]    child_mem [NODES];
	logic [ROW_W-1:0]    rdata_q;
	logic [NODE_W-1:0]   mem_raddr;
	logic                mem_we;
	logic [NODE_W-1:0]   mem_waddr;
	logic [LANES-1:0]    mem_lane_en;
	logic [NODE_W-1:0]   mem_wlane;
	logic                mem_wmark;

	logic [NODE_W-1:0]   lane_nxt;
	logic                rmark;
	logic                pool_full;

	assign pop       = (state_q == S_IDLE) && head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign emit      = emit_q;
	assign out_char  = out_char_q;
	assign status    = status_q;

	assign mem_raddr = head.func ? tcur_q : icur_q;
	assign rmark     = rdata_q[ROW_W-1];
	assign pool_full = (nfree_q >= FREE_W'(NODES));

	// child link for the latched letter
	always_comb begin
		lane_nxt = '0;
		for (int i = 0; i < ALPHABET; i++) begin
			if (LET_W'(i) == item_q.letter) lane_nxt = rdata_q[i*NODE_W +: NODE_W];
		end
	end

	// write port: root clear, link allocation, row clear, word mark
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = icur_q;
		mem_lane_en = '0;
		mem_wlane   = '0;
		mem_wmark   = 1'b0;
		case (state_q)
			S_INIT: begin
				mem_we      = 1'b1;
				mem_waddr   = '0;
				mem_lane_en = '1;
			end
			S_LOOK: begin
				if (!item_q.func) begin
					if (lane_nxt != '0) begin
						if (item_q.last) begin
							mem_we             = 1'b1;
							mem_waddr          = lane_nxt;
							mem_lane_en[ALPHABET] = 1'b1;
							mem_wmark          = 1'b1;
						end
					end else if (!pool_full) begin
						mem_we    = 1'b1;
						mem_wlane = nfree_q[NODE_W-1:0];
						for (int i = 0; i < ALPHABET; i++) begin
							mem_lane_en[i] = (LET_W'(i) == item_q.letter);
						end
					end
				end
			end
			S_CLEAR: begin
				mem_we      = 1'b1;
				mem_lane_en = '1;
				mem_wmark   = item_q.last;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int i = 0; i < ALPHABET; i++) begin
				if (mem_lane_en[i]) child_mem[mem_waddr][i*NODE_W +: NODE_W] <= mem_wlane;
			end
			if (mem_lane_en[ALPHABET]) child_mem[mem_waddr][ROW_W-1] <= mem_wmark;
		end
		rdata_q <= child_mem[mem_raddr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			tmode_q     <= M_MATCH;
			item_q      <= '0;
			tcur_q      <= '0;
			icur_q      <= '0;
			nfree_q     <= FREE_W'(1);
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			emit_q      <= 1'b0;
			out_char_q  <= '0;
			status_q    <= ST_OK;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						item_q <= head;
						if (head.func) begin
							if (head.is_space) begin
								tcur_q      <= '0;
								tmode_q     <= M_MATCH;
								out_valid_q <= 1'b1;
								emit_q      <= 1'b1;
								out_char_q  <= head.ch;
								status_q    <= ST_OK;
							end else if (tmode_q == M_SUPP) begin
								out_valid_q <= 1'b1;
								emit_q      <= 1'b0;
								out_char_q  <= '0;
								status_q    <= ST_OK;
							end else if (tmode_q != M_MATCH) begin
								out_valid_q <= 1'b1;
								emit_q      <= 1'b1;
								out_char_q  <= head.ch;
								status_q    <= ST_OK;
							end else begin
								state_q <= S_LOOK;
							end
						end else if (drop_q || !head.is_letter) begin
							out_valid_q <= 1'b1;
							emit_q      <= 1'b0;
							out_char_q  <= '0;
							status_q    <= drop_q ? ST_OK : ST_BADCH;
							if (head.last) begin
								icur_q <= '0;
								drop_q <= 1'b0;
							end else begin
								drop_q <= 1'b1;
							end
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (item_q.func) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						if (rmark) begin
							tmode_q    <= M_SUPP;
							emit_q     <= 1'b0;
							out_char_q <= '0;
						end else begin
							if (lane_nxt == '0 || !item_q.is_letter) tmode_q <= M_ECHO;
							else                                   tcur_q  <= lane_nxt;
							emit_q     <= 1'b1;
							out_char_q <= item_q.ch;
						end
					end else if (lane_nxt != '0) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						emit_q      <= 1'b0;
						out_char_q  <= '0;
						status_q    <= ST_OK;
						icur_q      <= item_q.last ? '0 : lane_nxt;
					end else if (pool_full) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						emit_q      <= 1'b0;
						out_char_q  <= '0;
						status_q    <= ST_FULL;
						if (item_q.last) begin
							icur_q <= '0;
							drop_q <= 1'b0;
						end else begin
							drop_q <= 1'b1;
						end
					end else begin
						// new node: link written now, its row cleared next
						nfree_q <= nfree_q + FREE_W'(1);
						icur_q  <= nfree_q[NODE_W-1:0];
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					emit_q      <= 1'b0;
					out_char_q  <= '0;
					status_q    <= ST_OK;
					if (item_q.last) icur_q <= '0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_emit_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(emit_q && (status_q != ST_OK)))
		else $error("text beat carries a dictionary status");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !emit_q) |-> (out_char_q == 8'h00))
		else $error("suppressed beat has a nonzero character");

	a_clear_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> ($past(state_q) == S_LOOK))
		else $error("row clear without an allocation");

	a_clear_new_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> ({1'b0, icur_q} == FREE_W'(nfree_q - FREE_W'(1))))
		else $error("row clear does not target the newest node");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= FREE_W'(NODES))
		else $error("free node count past the pool");

endmodule
`default_nettype wire

/* hw/rtl/trie_prefix_word_replacer.sv */
`default_nettype none
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    func, ch, word_end
// out       out  out_valid / out_ready  emit, out_char, status
//
// A text character needs no row read when no trie lookup is needed (space, or a
// word already decided), else it reads its node row through the child table's
// registered read. A dictionary letter needs no read on a drop or bad letter,
// a row read on an existing link or a full pool, and a row read, link write
// and row clear on a new node, both writes through the table's one write port.
// After reset the root row is cleared in the init state before the first item.
// A two-entry queue decouples the input side from the lookup engine; a held
// result stalls the engine, the input keeps filling the queue until it is full.
module trie_prefix_word_replacer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       func,
	input  wire logic [7:0] ch,
	input  wire logic       word_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            emit,
	output logic [7:0]      out_char,
	output logic [1:0]      status
);
	import tpr_pkg::*;

	logic  push;
	logic  push_ready;
	item_t push_item;
	logic  head_valid;
	item_t head;
	logic  pop;

	tpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.ch         (ch),
		.word_end   (word_end),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	tpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	tpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.emit       (emit),
		.out_char   (out_char),
		.status     (status)
	);

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	import tpr_pkg::*;

	localparam logic ITEM_DICT = 1'b0;
	localparam logic ITEM_TEXT = 1'b1;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BEATS  = 120;
	localparam int FILL_TAIL    = 80;
	localparam int ROOT_SLOTS   = 64;
	localparam int WORD_MAX     = 16;
	localparam int DIR_ROWS     = 27;

	// per phase: no idling, sender idle, receiver stalling, both
	localparam int SEND_IDLE  [4] = '{0, 62, 0, 20};
	localparam int RECV_STALL [4] = '{0, 0, 62, 20};

	typedef enum logic [1:0] {TXT_MATCH, TXT_ECHO, TXT_SUPPRESS} txt_mode_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] chr;
		logic [1:0] status;
	} beat_t;

	typedef struct packed {
		logic       func;
		logic [7:0] chr;
		logic       last;
		logic       typed;
		beat_t      res;
	} stim_row_t;

	// func, ch, word_end, typed, emit, out_char, status
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		{ITEM_TEXT, "a",   1'b0, 1'b1, 1'b1, "a",   ST_OK},    // empty trie: miss
		{ITEM_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, ST_OK},    // rest of word echoed
		{ITEM_TEXT, " ",   1'b0, 1'b1, 1'b1, " ",   ST_OK},
		{ITEM_DICT, "c",   1'b0, 1'b1, 1'b0, 8'h00, ST_OK},
		{ITEM_DICT, "a",   1'b0, 1'b1, 1'b0, 8'h00, ST_OK},
		{ITEM_DICT, "t",   1'b1, 1'b1, 1'b0, 8'h00, ST_OK},    // root "cat"
		{ITEM_DICT, "z",   1'b1, 1'b1, 1'b0, 8'h00, ST_OK},    // root "z"
		{ITEM_DICT, 8'h60, 1'b0, 1'b1, 1'b0, 8'h00, ST_BADCH}, // just below 'a'
		{ITEM_DICT, "q",   1'b0, 1'b1, 1'b0, 8'h00, ST_OK},    // dropped letter
		{ITEM_DICT, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, ST_OK},    // drop ends here
		{ITEM_DICT, 8'h7B, 1'b1, 1'b1, 1'b0, 8'h00, ST_BADCH}, // just above 'z', on end
		{ITEM_DICT, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, ST_BADCH},
		{ITEM_TEXT, "c",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "a",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "t",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "s",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},    // past root: suppressed
		{ITEM_TEXT, " ",   1'b1, 1'b1, 1'b1, " ",   ST_OK},
		{ITEM_TEXT, "c",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "a",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "t",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},    // word equals root
		{ITEM_TEXT, " ",   1'b0, 1'b1, 1'b1, " ",   ST_OK},
		{ITEM_TEXT, "z",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "z",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, " ",   1'b0, 1'b1, 1'b1, " ",   ST_OK},
		{ITEM_TEXT, "c",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
		{ITEM_TEXT, "1",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK},    // non-letter: miss
		{ITEM_TEXT, "t",   1'b0, 1'b0, 1'b0, 8'h00, ST_OK}
	};

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       func     = 1'b0;
	logic [7:0] ch       = 8'h00;
	logic       word_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       emit;
	logic [7:0] out_char;
	logic [1:0] status;

	trie_prefix_word_replacer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.ch       (ch),
		.word_end (word_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.emit     (emit),
		.out_char (out_char),
		.status   (status)
	);

	// trie copy kept in step with accepted input beats
	logic [NODE_W-1:0] trie_link [NODES*ALPHABET];
	logic              word_mark [NODES];
	logic [FREE_W-1:0] free_node;
	logic [NODE_W-1:0] ins_node;
	logic              ins_drop;
	logic [NODE_W-1:0] txt_node;
	txt_mode_t         txt_mode;

	beat_t replaced_text_q [$];

	// recent root words, reused to build text that hits the trie
	logic [7:0] root_chars [ROOT_SLOTS][WORD_MAX];
	int         root_len [ROOT_SLOTS];
	int         root_cnt = 0;
	logic [7:0] word_buf [WORD_MAX];
	int         word_len;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int err_cnt       = 0;
	int beats_sent    = 0;
	int cycle_cnt     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_A) && (c < CH_A + ALPHABET);
	endfunction

	// one beat through the trie: insert a dictionary letter or filter a text char
	function automatic beat_t trie_replace_step(input logic f, input logic [7:0] c,
			input logic l);
		beat_t             res;
		int                slot;
		logic [NODE_W-1:0] nxt;
		res = '0;
		if (f == ITEM_DICT) begin
			if (!ins_drop) begin
				if (!is_letter(c)) begin
					res.status = ST_BADCH;
					ins_drop = 1'b1;
				end else begin
					slot = int'(ins_node) * ALPHABET + int'(c - CH_A);
					if (trie_link[slot] == '0) begin
						if (free_node >= NODES) begin
							res.status = ST_FULL;
							ins_drop = 1'b1;
						end else begin
							trie_link[slot] = NODE_W'(free_node);
							free_node = free_node + 1'b1;
						end
					end
					if (!ins_drop)
						ins_node = trie_link[slot];
				end
				if (!ins_drop && l)
					word_mark[ins_node] = 1'b1;
			end
			if (l) begin
				ins_node = '0;
				ins_drop = 1'b0;
			end
		end else begin
			res.emit = 1'b1;
			if (c == CH_SPACE) begin
				txt_node = '0;
				txt_mode = TXT_MATCH;
			end else if (txt_mode == TXT_SUPPRESS) begin
				res.emit = 1'b0;
			end else if (txt_mode == TXT_MATCH) begin
				if (word_mark[txt_node]) begin
					txt_mode = TXT_SUPPRESS;
					res.emit = 1'b0;
				end else begin
					nxt = '0;
					if (is_letter(c))
						nxt = trie_link[int'(txt_node) * ALPHABET + int'(c - CH_A)];
					if (nxt == '0)
						txt_mode = TXT_ECHO;
					else
						txt_node = nxt;
				end
			end
			if (res.emit)
				res.chr = c;
		end
		return res;
	endfunction

	// offer one beat, wait for it to be taken, then queue its predicted result (or the table's fixed one)
	task automatic push_beat(input logic f, input logic [7:0] c, input logic l,
			input logic typed, input beat_t fixed);
		beat_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		ch       <= c;
		word_end <= l;
		do @(posedge clk); while (!in_ready);
		res = trie_replace_step(f, c, l);
		if (typed)
			res = fixed;
		replaced_text_q = {replaced_text_q, res};
		beats_sent++;
	endtask

	// narrow letters make words share prefixes
	function automatic logic [7:0] rand_letter(input logic narrow);
		if (narrow && $urandom_range(1) == 1)
			return 8'(CH_A + $urandom_range(4));
		return 8'(CH_A + $urandom_range(ALPHABET - 1));
	endfunction

	// fresh letters, or a known root cut short or lengthened
	task automatic build_word(input logic from_roots, input int max_len, input logic narrow);
		int r;
		int extra;
		int k;
		if (from_roots && root_cnt > 0) begin
			r = $urandom_range(((root_cnt < ROOT_SLOTS) ? root_cnt : ROOT_SLOTS) - 1);
			word_len = root_len[r];
			for (k = 0; k < word_len; k++)
				word_buf[k] = root_chars[r][k];
			case ($urandom_range(2))
				0: word_len = $urandom_range(word_len, 1);
				1: begin
					extra = $urandom_range(3, 1);
					for (k = 0; k < extra && word_len < WORD_MAX; k++) begin
						word_buf[word_len] = rand_letter(narrow);
						word_len++;
					end
				end
				default: ;
			endcase
		end else begin
			word_len = $urandom_range(max_len, 1);
			for (k = 0; k < word_len; k++)
				word_buf[k] = rand_letter(narrow);
		end
	endtask

	// a root word, a text word with its spaces, or a stray beat
	task automatic send_random_word(input logic fill);
		int r;
		int k;
		int bad;
		r = $urandom_range(99);
		if (r < 3) begin
			push_beat(1'($urandom_range(1)), 8'($urandom_range(255)),
				1'($urandom_range(1)), 1'b0, '0);
		end else if (r < (fill ? 97 : 40)) begin
			// fill words are fresh and long so that most letters take a new node
			build_word(!fill && ($urandom_range(99) < 30), fill ? WORD_MAX : 6, !fill);
			bad = ($urandom_range(99) < 5) ? int'($urandom_range(word_len - 1)) : -1;
			if (bad >= 0) begin
				word_buf[bad] = 8'($urandom_range(255));
			end else begin
				root_len[root_cnt % ROOT_SLOTS] = word_len;
				for (k = 0; k < word_len; k++)
					root_chars[root_cnt % ROOT_SLOTS][k] = word_buf[k];
				root_cnt++;
			end
			for (k = 0; k < word_len; k++)
				push_beat(ITEM_DICT, word_buf[k], k == word_len - 1, 1'b0, '0);
		end else begin
			build_word($urandom_range(99) < 65, 6, 1'b1);
			if ($urandom_range(99) < 8)
				word_buf[$urandom_range(word_len - 1)] = 8'($urandom_range(255));
			for (k = 0; k < word_len; k++)
				push_beat(ITEM_TEXT, word_buf[k], 1'($urandom_range(1)), 1'b0, '0);
			push_beat(ITEM_TEXT, CH_SPACE, 1'($urandom_range(1)), 1'b0, '0);
			if ($urandom_range(99) < 10)
				push_beat(ITEM_TEXT, CH_SPACE, 1'($urandom_range(1)), 1'b0, '0);
		end
	endtask

	// result side: check each taken beat, then pick the next ready
	always @(posedge clk) begin : rx_side
		beat_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (replaced_text_q.size() == 0) begin
				$error("result beat with nothing pending: out_char %0h", out_char);
				err_cnt++;
			end else begin
				want = replaced_text_q.pop_front();
				if (emit !== want.emit) begin
					$error("emit: expected %0d, got %0d", want.emit, emit);
					err_cnt++;
				end
				if (out_char !== want.chr) begin
					$error("out_char: expected %0h, got %0h", want.chr, out_char);
					err_cnt++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					err_cnt++;
				end
			end
		end
		// long hold-off lets the input side fill up and stall
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : stimulus
		int i;
		int ph;
		int start;
		for (i = 0; i < NODES * ALPHABET; i++)
			trie_link[i] = '0;
		for (i = 0; i < NODES; i++)
			word_mark[i] = 1'b0;
		free_node = 1;
		ins_node  = '0;
		ins_drop  = 1'b0;
		txt_node  = '0;
		txt_mode  = TXT_MATCH;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (i = 0; i < DIR_ROWS; i++)
			push_beat(DIR_TABLE[i].func, DIR_TABLE[i].chr, DIR_TABLE[i].last,
				DIR_TABLE[i].typed, DIR_TABLE[i].res);

		// random phases; the third one fills the node pool, then runs on past full
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct     = RECV_STALL[ph];
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 2) begin
				while (free_node < NODES)
					send_random_word(1'b1);
				start = beats_sent;
				while (beats_sent - start < FILL_TAIL)
					send_random_word(1'b0);
			end else begin
				start = beats_sent;
				while (beats_sent - start < PHASE_BEATS)
					send_random_word(1'b0);
			end
		end
		in_valid <= 1'b0;

		while (replaced_text_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
